// ----- rtl/lpds_pkg.sv -----
// Shared types and constants for the point-to-line distance sum block.
package lpds_pkg;

	// Default fraction width of the signed fixed-point coordinates
	localparam int FRAC_BITS_DEF = 16;

	// Field and datapath widths
	localparam int COORD_W   = 32;
	localparam int SUM_W     = 64;
	localparam int QUO_W     = 64;
	localparam int LIMB_W    = 32;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int NUM_RAW_W = 130;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_INTERCEPT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_SLOPE     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_INTERCEPT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SLOPE     = 2'd3;

	// One hit point
	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic                      final_point;
	} point_t;

	// One emitted sum
	typedef struct packed {
		logic [SUM_W-1:0] distance_sum;
		logic             sum_saturated;
	} result_t;

	// Divider status towards the sequencer
	typedef struct packed {
		logic done;
		logic sat;
	} div_stat_t;

endpackage

// ----- rtl/lpds_mul.sv -----
// Shared signed multiplier with a registered product.
module lpds_mul (
	input  logic                                clk,
	input  logic signed [lpds_pkg::MUL_W-1:0]  a,
	input  logic signed [lpds_pkg::MUL_W-1:0]  b,
	output logic signed [lpds_pkg::PROD_W-1:0] p_q
);

	// Register the full-width product
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ----- rtl/lpds_div.sv -----
// Restoring divider, one quotient bit per cycle, with an overflow check up front.
module lpds_div #(
	parameter int NUM_W = lpds_pkg::NUM_RAW_W,
	parameter int DEN_W = lpds_pkg::SUM_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [NUM_W-1:0]                num,
	input  logic [DEN_W-1:0]                den,
	output lpds_pkg::div_stat_t             stat,
	output logic [lpds_pkg::QUO_W-1:0]      quo
);

	localparam int QW    = lpds_pkg::QUO_W;
	localparam int HI_W  = NUM_W - QW;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;
	localparam int CNT_W = $clog2(QW);

	typedef enum logic [1:0] {
		D_IDLE = 2'b01,
		D_RUN  = 2'b10
	} dstate_t;

	dstate_t            state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;
	logic               sat_q;
	logic [DEN_W-1:0]   rem_q;
	logic [DEN_W-1:0]   den_q;
	logic [QW-1:0]      lo_q;

	logic               hi_ge;
	logic [DEN_W:0]     trial;
	logic [DEN_W:0]     diff;
	logic               fits;
	logic [DEN_W-1:0]   rem_next;

	// Quotient would not fit in 64 bits when the upper numerator reaches the divisor
	assign hi_ge = CMP_W'(num[NUM_W-1:QW]) >= CMP_W'(den);

	// One trial subtraction per cycle
	always_comb begin
		trial    = {rem_q, lo_q[QW-1]};
		diff     = trial - {1'b0, den_q};
		fits     = trial >= {1'b0, den_q};
		rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	end

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						sat_q <= hi_ge;
						cnt_q <= '0;
						if (hi_ge) begin
							done_q <= 1'b1;
						end else begin
							state_q <= D_RUN;
						end
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(QW - 1)) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	// Load operands, then shift quotient bits in behind the numerator bits
	always_ff @(posedge clk) begin
		if (state_q == D_IDLE && start) begin
			rem_q <= DEN_W'(num[NUM_W-1:QW]);
			lo_q  <= num[QW-1:0];
			den_q <= den;
		end else if (state_q == D_RUN) begin
			rem_q <= rem_next;
			lo_q  <= {lo_q[QW-2:0], fits};
		end
	end

	assign stat.done = done_q;
	assign stat.sat  = sat_q;
	assign quo       = lo_q;

endmodule

// ----- rtl/line_point_distance_sum_top.sv -----
// Top level: sums squared 3D point-to-line distances over a set of hit points.
//
// Usage. Write the four line registers (x intercept, x slope, y intercept,
// y slope, indexes 0 to 3) through cfg_we/cfg_index/cfg_data while the block
// is idle; each write lands at the clock edge where cfg_we is high.
// Hit points enter on in_valid/in_ready, and a new point is accepted only
// once the previous one is through: the shared 33x33 multiplier runs its
// schedule (cross product, slope squares, 64-bit squares as 32-bit partial
// products), the divide is launched and runs in the bit-serial divider, the
// term is folded and the idle state takes the next item; a final point
// adds the output load. A term too large for 64 bits skips the serial divide.
// Only a point marked final produces a result: the running sum including
// that point, with a flag if any term or the sum saturated. The result sits
// in an output register on out_valid/out_ready and the accumulator clears.
// If the receiver stalls, the next set is still taken; a second final point
// waits only until the pending result has been taken.
// Reset clears the line registers, the sum and the saturation flag and
// leaves the block idle and ready.
module line_point_distance_sum_top #(
	parameter int FRAC_BITS = lpds_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lpds_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpds_pkg::COORD_W-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  lpds_pkg::point_t                   in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output lpds_pkg::result_t                  out_data
);

	localparam int CW      = lpds_pkg::COORD_W;
	localparam int SW      = lpds_pkg::SUM_W;
	localparam int LW      = lpds_pkg::LIMB_W;
	localparam int MW      = lpds_pkg::MUL_W;
	localparam int PW      = lpds_pkg::PROD_W;
	localparam int RAW_W   = lpds_pkg::NUM_RAW_W;
	localparam int NUM_SHL = (2 * FRAC_BITS <= 32) ? 32 - 2 * FRAC_BITS : 0;
	localparam int DEN_SHL = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
	localparam int NUM_W   = RAW_W + NUM_SHL;
	localparam int DEN_W   = SW + DEN_SHL;
	localparam logic [SW-1:0] ONE_SQ = SW'(1) << (2 * FRAC_BITS);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_MUL   = 5'b00010,
		S_START = 5'b00100,
		S_DIV   = 5'b01000,
		S_EMIT  = 5'b10000
	} state_t;

	// Multiplier schedule, one operation per cycle
	typedef enum logic [3:0] {
		M_WZ_YS, M_WZ_XS, M_WX_YS, M_WY_XS, M_XS_XS, M_YS_YS,
		M_CX_LL, M_CX_LH, M_CX_HH,
		M_CY_LL, M_CY_LH, M_CY_HH,
		M_CZ_LL, M_CZ_LH, M_CZ_HH,
		M_DRAIN
	} mstep_t;

	function automatic logic [SW-1:0] mag64(input logic signed [PW-1:0] d);
		logic signed [PW-1:0] n;
		n = -d;
		return d[PW-1] ? n[SW-1:0] : d[SW-1:0];
	endfunction

	state_t                  state_q;
	mstep_t                  step_q;
	mstep_t                  last_q;
	logic                    prod_ok_q;
	logic [SW-1:0]           total_q;
	logic                    ovf_q;
	logic                    out_valid_q;
	lpds_pkg::result_t       out_q;

	logic signed [CW-1:0]    xi_q, xs_q, yi_q, ys_q;
	logic signed [MW-1:0]    wx_q, wy_q, wz_q;
	logic                    final_q;
	logic [SW-1:0]           cx_q, cy_q, cz_q;
	logic signed [PW-1:0]    tmp_q;
	logic [SW-1:0]           den_q;
	logic [RAW_W-1:0]        num_q;

	logic signed [MW-1:0]    mul_a, mul_b;
	logic signed [PW-1:0]    prod;
	logic signed [PW-1:0]    wxf, wyf;
	logic                    accept;
	logic                    div_start;
	lpds_pkg::div_stat_t     div_stat;
	logic [SW-1:0]           quo;
	logic [SW-1:0]           term;
	logic [SW:0]             sum_ext;
	logic [SW-1:0]           new_total;
	logic                    new_ovf;
	logic                    emit_load;

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign div_start = (state_q == S_START);
	assign emit_load = (state_q == S_EMIT) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xi_q <= '0;
			xs_q <= '0;
			yi_q <= '0;
			ys_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpds_pkg::REG_X_INTERCEPT: xi_q <= cfg_data;
				lpds_pkg::REG_X_SLOPE:     xs_q <= cfg_data;
				lpds_pkg::REG_Y_INTERCEPT: yi_q <= cfg_data;
				lpds_pkg::REG_Y_SLOPE:     ys_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pick multiplier operands for the current step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			M_WZ_YS: begin mul_a = wz_q; mul_b = MW'(ys_q); end
			M_WZ_XS: begin mul_a = wz_q; mul_b = MW'(xs_q); end
			M_WX_YS: begin mul_a = wx_q; mul_b = MW'(ys_q); end
			M_WY_XS: begin mul_a = wy_q; mul_b = MW'(xs_q); end
			M_XS_XS: begin mul_a = MW'(xs_q); mul_b = MW'(xs_q); end
			M_YS_YS: begin mul_a = MW'(ys_q); mul_b = MW'(ys_q); end
			M_CX_LL: begin
				mul_a = $signed({1'b0, cx_q[LW-1:0]});
				mul_b = $signed({1'b0, cx_q[LW-1:0]});
			end
			M_CX_LH: begin
				mul_a = $signed({1'b0, cx_q[LW-1:0]});
				mul_b = $signed({1'b0, cx_q[SW-1:LW]});
			end
			M_CX_HH: begin
				mul_a = $signed({1'b0, cx_q[SW-1:LW]});
				mul_b = $signed({1'b0, cx_q[SW-1:LW]});
			end
			M_CY_LL: begin
				mul_a = $signed({1'b0, cy_q[LW-1:0]});
				mul_b = $signed({1'b0, cy_q[LW-1:0]});
			end
			M_CY_LH: begin
				mul_a = $signed({1'b0, cy_q[LW-1:0]});
				mul_b = $signed({1'b0, cy_q[SW-1:LW]});
			end
			M_CY_HH: begin
				mul_a = $signed({1'b0, cy_q[SW-1:LW]});
				mul_b = $signed({1'b0, cy_q[SW-1:LW]});
			end
			M_CZ_LL: begin
				mul_a = $signed({1'b0, cz_q[LW-1:0]});
				mul_b = $signed({1'b0, cz_q[LW-1:0]});
			end
			M_CZ_LH: begin
				mul_a = $signed({1'b0, cz_q[LW-1:0]});
				mul_b = $signed({1'b0, cz_q[SW-1:LW]});
			end
			M_CZ_HH: begin
				mul_a = $signed({1'b0, cz_q[SW-1:LW]});
				mul_b = $signed({1'b0, cz_q[SW-1:LW]});
			end
			M_DRAIN: begin mul_a = '0; mul_b = '0; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	lpds_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	// Point offsets scaled to the product's fraction
	always_comb begin
		wxf = $signed({{(PW - MW){wx_q[MW-1]}}, wx_q}) <<< FRAC_BITS;
		wyf = $signed({{(PW - MW){wy_q[MW-1]}}, wy_q}) <<< FRAC_BITS;
	end

	// Capture the point, then fold each product into the cross terms and sums
	always_ff @(posedge clk) begin
		last_q <= step_q;
		if (accept) begin
			wx_q    <= $signed({in_data.point_x[CW-1], in_data.point_x})
			         - $signed({xi_q[CW-1], xi_q});
			wy_q    <= $signed({in_data.point_y[CW-1], in_data.point_y})
			         - $signed({yi_q[CW-1], yi_q});
			wz_q    <= $signed({in_data.point_z[CW-1], in_data.point_z});
			final_q <= in_data.final_point;
			num_q   <= '0;
		end else if (prod_ok_q) begin
			case (last_q) inside
				M_WZ_YS: cx_q  <= mag64(wyf - prod);
				M_WZ_XS: cy_q  <= mag64(prod - wxf);
				M_WX_YS: tmp_q <= prod;
				M_WY_XS: cz_q  <= mag64(tmp_q - prod);
				M_XS_XS: den_q <= ONE_SQ + prod[SW-1:0];
				M_YS_YS: den_q <= den_q + prod[SW-1:0];
				M_CX_LL, M_CY_LL, M_CZ_LL:
					num_q <= num_q + RAW_W'(prod[SW-1:0]);
				M_CX_LH, M_CY_LH, M_CZ_LH:
					num_q <= num_q + (RAW_W'(prod[SW-1:0]) << (LW + 1));
				M_CX_HH, M_CY_HH, M_CZ_HH:
					num_q <= num_q + (RAW_W'(prod[SW-1:0]) << (2 * LW));
				default: ;
			endcase
		end
	end

	lpds_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (NUM_W'(num_q) << NUM_SHL),
		.den    (DEN_W'(den_q) << DEN_SHL),
		.stat   (div_stat),
		.quo    (quo)
	);

	// Saturating accumulation of the finished term
	always_comb begin
		term      = div_stat.sat ? {SW{1'b1}} : quo;
		sum_ext   = {1'b0, total_q} + {1'b0, term};
		new_total = sum_ext[SW] ? {SW{1'b1}} : sum_ext[SW-1:0];
		new_ovf   = ovf_q || div_stat.sat || sum_ext[SW];
	end

	// Sequencer, accumulator and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= M_WZ_YS;
			prod_ok_q   <= 1'b0;
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			prod_ok_q <= (state_q == S_MUL) && (step_q != M_DRAIN);
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_MUL;
						step_q  <= M_WZ_YS;
					end
				end
				S_MUL: begin
					if (step_q == M_DRAIN) begin
						state_q <= S_START;
					end else begin
						step_q <= mstep_t'(step_q + 4'd1);
					end
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						total_q <= new_total;
						ovf_q   <= new_ovf;
						state_q <= final_q ? S_EMIT : S_IDLE;
					end
				end
				S_EMIT: begin
					if (emit_load) begin
						total_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Hold the emitted sum
	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_q.distance_sum  <= total_q;
			out_q.sum_saturated <= ovf_q;
		end
	end

	// The divider only reports back while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == S_DIV)
		else $error("divider finished outside the divide wait");

	// An accepted item starts the multiply schedule from a cleared numerator
	a_accept_starts_mul: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_MUL && step_q == M_WZ_YS && num_q == '0))
		else $error("accepted item did not start the multiply schedule");

	// Emitting a sum clears the accumulator and presents the result
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> (total_q == '0 && !ovf_q && out_valid && state_q == S_IDLE))
		else $error("accumulator not cleared after emitting a sum");

endmodule
